/* rtl/vbe_pkg.sv */
// ----------------------------------------------------------------------------
// vbe_pkg
// Shared types and constants for the vertical bit-pack encoder.
// ----------------------------------------------------------------------------
package vbe_pkg;

    localparam int GAP_WIDTH  = 32;
    localparam int SEL_WIDTH  = 6;
    localparam int LANE_WIDTH = 4;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    localparam logic KIND_SEL  = 1'b0;
    localparam logic KIND_LANE = 1'b1;

    typedef logic [GAP_WIDTH-1:0] gap_t;
    typedef logic [SEL_WIDTH-1:0] sel_t;

endpackage

/* rtl/vbe_bitlen.sv */
// ----------------------------------------------------------------------------
// vbe_bitlen
// Iterative bit-length unit: one halving compare-and-shift step per cycle.
// ----------------------------------------------------------------------------
module vbe_bitlen (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  vbe_pkg::gap_t     value,
    output logic              done,
    output vbe_pkg::sel_t     width
);
    import vbe_pkg::*;

    localparam int STEPS = 5;

    gap_t         x_reg, x_next;
    sel_t         r_reg, r_next;
    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic         zero_reg, zero_next;
    logic [4:0]   amt;
    logic         top_zero;

    assign amt      = 5'd16 >> step_reg;
    assign top_zero = (x_reg >> (6'd32 - 6'(amt))) == '0;

    always_comb begin
        x_next    = x_reg;
        r_next    = r_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        if (start) begin
            x_next    = value;
            r_next    = sel_t'(GAP_WIDTH);
            step_next = '0;
            busy_next = 1'b1;
            zero_next = (value == '0);
        end else if (busy_reg) begin
            if (top_zero) begin
                x_next = x_reg << amt;
                r_next = r_reg - sel_t'(amt);
            end
            step_next = step_reg + 3'd1;
            if (step_reg == 3'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        r_reg    <= r_next;
        zero_reg <= zero_next;
    end

    assign done  = done_reg;
    assign width = zero_reg ? sel_t'(1) : r_reg;

endmodule

/* rtl/vertical_bitpack_encoder_unit.sv */
// ----------------------------------------------------------------------------
// vertical_bitpack_encoder_unit
// Gathers d-gaps into columns of LANES values and packs the columns into
// words of LANES lane words, emitting selectors and packed lane words.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser | tlast
//  s_      | in  | gap_value[31:0]                           | -     | end_of_list
//  m_      | out | out_value[31:0] lane[3:0] last[0] pad[2:0] | kind  | list_done
//
//  An item that does not close a column leaves s_ ready for the next item.
//  A closing item starts the bit-length unit; then the open word spills lane by
//  lane if the column does not fit, the selector goes out, the column is merged
//  lane by lane, and the word spills at the list end; s_tready stays low until
//  the column is done. A stalled m_ channel holds the sequence.
//  aresetn is synchronous; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module vertical_bitpack_encoder_unit #(
    parameter int LANES     = 16,
    parameter int LANE_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vbe_pkg::S_TDATA_W-1:0]  s_tdata,   // gap_value[31:0]
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vbe_pkg::M_TDATA_W-1:0]  m_tdata,   // out_value, lane, last, pad
    output logic                           m_tuser,   // kind
    output logic                           m_tlast
);
    import vbe_pkg::*;

    localparam int GAP_W  = (LANE_BITS < GAP_WIDTH) ? LANE_BITS : GAP_WIDTH;
    localparam int IDX_W  = $clog2(LANES);
    localparam int FILL_W = $clog2(LANES + 1);
    localparam int BITS_W = $clog2(LANE_BITS + 1);
    localparam int SUM_W  = ((BITS_W > SEL_WIDTH) ? BITS_W : SEL_WIDTH) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LEN   = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_SEL   = 3'd3;
    localparam logic [2:0] ST_MERGE = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic [GAP_W-1:0]     column_store [LANES];
    logic [LANE_BITS-1:0] word_lanes_reg [LANES];

    logic [2:0]        state_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [GAP_W-1:0]  column_or_reg;
    logic [BITS_W-1:0] bits_used_reg;
    logic              has_cols_reg;
    logic              end_reg;
    logic [IDX_W-1:0]  idx_reg;
    sel_t              w_reg;

    logic              m_valid_reg;
    logic              m_kind_reg;
    logic [31:0]       m_value_reg;
    logic [3:0]        m_lane_reg;
    logic              m_last_reg;
    logic              m_done_reg;

    logic              s_fire;
    logic              out_free;
    logic              m_load;
    logic [GAP_W-1:0]  gap;
    logic [GAP_W-1:0]  column_or_next;
    logic              closing;
    logic              len_done;
    sel_t              len_width;
    logic [SUM_W-1:0]  bits_sum;
    logic              last_idx;

    assign s_tready       = (state_reg == ST_IDLE);
    assign s_fire         = s_tvalid && s_tready;
    assign out_free       = !m_valid_reg || m_tready;
    assign m_load         = out_free && (state_reg inside {ST_FLUSH, ST_FINAL, ST_SEL});
    assign gap            = GAP_W'(s_tdata);
    assign column_or_next = column_or_reg | gap;
    assign closing        = (fill_reg == FILL_W'(LANES - 1)) || s_tlast;
    assign bits_sum       = SUM_W'(bits_used_reg) + SUM_W'(len_width);
    assign last_idx       = (idx_reg == IDX_W'(LANES - 1));

    vbe_bitlen u_bitlen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_fire && closing),
        .value   (gap_t'(column_or_next)),
        .done    (len_done),
        .width   (len_width)
    );

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            column_store[fill_reg[IDX_W-1:0]] <= gap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            column_or_reg <= '0;
            bits_used_reg <= '0;
            has_cols_reg  <= 1'b0;
            end_reg       <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                word_lanes_reg[i] <= '0;
            end
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        fill_reg      <= fill_reg + FILL_W'(1);
                        column_or_reg <= column_or_next;
                        end_reg       <= s_tlast;
                        if (closing) begin
                            state_reg <= ST_LEN;
                        end
                    end
                end
                ST_LEN: begin
                    if (len_done) begin
                        w_reg   <= len_width;
                        idx_reg <= '0;
                        if (has_cols_reg && (bits_sum > SUM_W'(LANE_BITS))) begin
                            state_reg <= ST_FLUSH;
                        end else begin
                            state_reg <= ST_SEL;
                        end
                    end
                end
                ST_FLUSH, ST_FINAL: begin
                    if (out_free) begin
                        m_kind_reg              <= KIND_LANE;
                        m_value_reg             <= 32'(word_lanes_reg[idx_reg]);
                        m_lane_reg              <= 4'(idx_reg);
                        m_last_reg              <= (state_reg == ST_FINAL) && last_idx;
                        m_done_reg              <= (state_reg == ST_FINAL) && last_idx;
                        word_lanes_reg[idx_reg] <= '0;
                        if (last_idx) begin
                            idx_reg       <= '0;
                            bits_used_reg <= '0;
                            has_cols_reg  <= 1'b0;
                            state_reg     <= (state_reg == ST_FLUSH) ? ST_SEL : ST_IDLE;
                        end else begin
                            idx_reg       <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                ST_SEL: begin
                    if (out_free) begin
                        m_kind_reg  <= KIND_SEL;
                        m_value_reg <= 32'(w_reg);
                        m_lane_reg  <= '0;
                        m_last_reg  <= !end_reg;
                        m_done_reg  <= 1'b0;
                        idx_reg     <= '0;
                        state_reg   <= ST_MERGE;
                    end
                end
                ST_MERGE: begin
                    word_lanes_reg[idx_reg] <= word_lanes_reg[idx_reg]
                        | (LANE_BITS'(column_store[idx_reg]) << bits_used_reg);
                    if ((FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg) begin
                        idx_reg       <= '0;
                        bits_used_reg <= bits_used_reg + BITS_W'(w_reg);
                        has_cols_reg  <= 1'b1;
                        fill_reg      <= '0;
                        column_or_reg <= '0;
                        state_reg     <= end_reg ? ST_FINAL : ST_IDLE;
                    end else begin
                        idx_reg       <= idx_reg + IDX_W'(1);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_last_reg, m_lane_reg, m_value_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_done_reg;

endmodule

/* tb/sv/vbe_pack_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbe_pack_checker
// Watches both streams of the vertical bit-pack encoder. Every gap transfer
// runs through a bit-accurate packer that queues the selectors and lane words
// owed. Every result transfer is checked field by field against the oldest
// one in that queue.
// ----------------------------------------------------------------------------
module vbe_pack_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [vbe_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [vbe_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tuser,
    input  logic                          m_tlast,
    output int                            mismatches,
    output int                            pending,
    output int                            results_checked
);
    import vbe_pkg::*;

    localparam int LANES      = 16;
    localparam int WORD_BITS  = GAP_WIDTH;

    typedef struct packed {
        logic                  kind;
        logic [31:0]           value;
        logic [LANE_WIDTH-1:0] lane;
        logic                  last;
        logic                  done;
    } pack_out_t;

    gap_t        col_vals  [LANES];
    gap_t        word_lane [LANES];
    int unsigned col_fill;
    gap_t        col_or;
    int unsigned used_bits;
    bit          word_open;
    pack_out_t   owed [$];

    function automatic sel_t col_bit_length(gap_t v);
        for (int b = GAP_WIDTH - 1; b >= 0; b--) begin
            if (v[b]) return sel_t'(b + 1);
        end
        return sel_t'(1);
    endfunction

    function automatic void clear_packer();
        foreach (word_lane[i]) word_lane[i] = '0;
        col_fill  = 0;
        col_or    = '0;
        used_bits = 0;
        word_open = 1'b0;
    endfunction

    function automatic void spill_word();
        for (int i = 0; i < LANES; i++) begin
            owed.push_back('{kind: KIND_LANE, value: word_lane[i], lane: LANE_WIDTH'(i),
                             last: 1'b0, done: 1'b0});
            word_lane[i] = '0;
        end
        used_bits = 0;
        word_open = 1'b0;
    endfunction

    function automatic void pack_gap(gap_t g, logic eol);
        sel_t        w;
        int unsigned owed_before;
        owed_before        = owed.size();
        col_vals[col_fill] = g;
        col_fill++;
        col_or |= g;
        if (col_fill == LANES || eol) begin
            w = col_bit_length(col_or);
            if (word_open && used_bits + w > WORD_BITS) spill_word();
            owed.push_back('{kind: KIND_SEL, value: 32'(w), lane: '0,
                             last: 1'b0, done: 1'b0});
            // lanes past a short column are left unchanged
            for (int i = 0; i < col_fill; i++) word_lane[i] |= col_vals[i] << used_bits;
            used_bits += w;
            word_open = 1'b1;
            col_fill  = 0;
            col_or    = '0;
        end
        if (eol) begin
            spill_word();
            clear_packer();
        end
        if (owed.size() > owed_before) begin
            owed[owed.size() - 1].last = 1'b1;
            if (eol) owed[owed.size() - 1].done = 1'b1;
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] result %0d: %s got %h, expected %h",
                 $time, results_checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        pack_out_t want;
        if (!aresetn) begin
            clear_packer();
            owed.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (owed.size() == 0) begin
                    flag_mismatch("result with nothing owed", m_tdata[31:0], '0);
                end else begin
                    want = owed.pop_front();
                    if (m_tuser !== want.kind)
                        flag_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                    if (m_tdata[31:0] !== want.value)
                        flag_mismatch("out_value", m_tdata[31:0], want.value);
                    if (m_tdata[35:32] !== want.lane)
                        flag_mismatch("lane", 32'(m_tdata[35:32]), 32'(want.lane));
                    if (m_tdata[36] !== want.last)
                        flag_mismatch("last", 32'(m_tdata[36]), 32'(want.last));
                    if (m_tlast !== want.done)
                        flag_mismatch("list_done", 32'(m_tlast), 32'(want.done));
                end
            end
            if (s_tvalid && s_tready) pack_gap(s_tdata[GAP_WIDTH-1:0], s_tlast);
        end
        pending <= owed.size();
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the vertical bit-pack encoder: a directed set of short lists,
// zero and full-width columns and an exact 32-bit fill, then random lists of
// mixed column widths under four idle mixes and one long output hold. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import vbe_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_GAPS    = 32;
    localparam int SETTLE_CYCLES = 100;
    localparam int IDLE_MIX  [4] = '{0, 80, 0, 13};
    localparam int STALL_MIX [4] = '{0, 0, 80, 13};

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    logic hold_req   = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;
    int   recv_stall = 0;
    int   send_idle  = 0;
    int   gaps_sent  = 0;
    int   lists_sent = 0;
    int   mismatches;
    int   pending;
    int   results_checked;

    vertical_bitpack_encoder_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    vbe_pack_checker pack_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result side: long hold on request, random stall otherwise
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic gap_t draw_gap(int span);
        gap_t g;
        if (span == 0) return '0;
        g = $urandom >> (GAP_WIDTH - span);
        if ($urandom_range(1) == 1) g[span-1] = 1'b1;
        return g;
    endfunction

    task automatic push_gap(input gap_t g, input logic eol);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= g;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gaps_sent++;
        if (eol) lists_sent++;
    endtask

    task automatic send_list(input int len);
        int span;
        span = 0;
        for (int k = 0; k < len; k++) begin
            // new width class per column, small widths half the time
            if (k % 16 == 0)
                span = ($urandom_range(1) == 1) ? $urandom_range(0, 8) : $urandom_range(9, 32);
            push_gap(draw_gap(span), k == len - 1);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int len;
        int budget;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-gap lists: all-zero column, full width, top bit only, bit 0 only
        push_gap(32'h0000_0000, 1'b1);
        push_gap(32'hFFFF_FFFF, 1'b1);
        push_gap(32'h8000_0000, 1'b1);
        push_gap(32'h0000_0001, 1'b1);
        // 16-bit column then a short 16-bit column: exact fill held to list end
        push_gap(32'h0000_FFFF, 1'b0);
        push_gap(32'h0000_8000, 1'b0);
        push_gap(32'h0000_0000, 1'b0);
        push_gap(32'h0000_0001, 1'b0);
        for (int k = 0; k < 12; k++) push_gap($urandom & 32'h0000_7FFF, 1'b0);
        push_gap(32'h0000_C001, 1'b1);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle  = IDLE_MIX[phase];
            recv_stall <= STALL_MIX[phase];
            budget = PHASE_GAPS;
            while (budget > 0) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 72);
                if (len > budget) len = budget;
                send_list(len);
                budget -= len;
            end
            drain_results();
        end

        // back-pressure: output held while gaps keep coming
        send_idle  = 0;
        recv_stall <= 0;
        hold_req   <= ~hold_req;
        send_list(PHASE_GAPS);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d gaps in %0d lists; checked %0d selectors and lane words.",
                 gaps_sent, lists_sent, results_checked);
        $display("Idle mixes: none, sender, receiver, both light; one %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #24_000_000;
        $display("Timeout with %0d results still owed.", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
